// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRR_CHK_NOW(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bit reservoir check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRR_CHK_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bit reservoir check failed");

`endif

// File: rtl/core/brr_pkg.sv
`default_nettype none

package brr_pkg;

  // Default store size in bytes.
  localparam int STORE_BYTES_DEF = 4096;

  // Fill limit after reset.
  localparam logic [11:0] FILL_LIMIT_RST = 12'd2048;

  // Request operation codes.
  localparam logic [1:0] MODE_APPEND     = 2'd0;
  localparam logic [1:0] MODE_GET        = 2'd1;
  localparam logic [1:0] MODE_SKIP_BITS  = 2'd2;
  localparam logic [1:0] MODE_SKIP_BYTES = 2'd3;

  // Largest bit count returned by one get, and the width of the read window.
  localparam int GET_MAX  = 17;
  localparam int WIN_BITS = 24;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic copy_step;
    logic rd_issue;
    logic commit;
  } brr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_copy;
    logic get_nz;
    logic copy_done;
    logic rd_last;
    logic slot_free;
  } brr_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/brr_ram.sv
`default_nettype none

module brr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/brr_ctrl.sv
`default_nettype none

module brr_ctrl import brr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  brr_sts_t sts,
  output brr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RWAIT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_copy) begin
          state_next = S_COPY;
        end else if (sts.get_nz) begin
          state_next = S_READ;
        end else if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_next = S_RWAIT;
        end
      end
      S_RWAIT: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/brr_dp.sv
`default_nettype none

module brr_dp import brr_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  localparam int POS_W = $clog2(STORE_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_wdata,
  input  logic [1:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic             chunk_start,
  input  logic [11:0]      chunk_len,
  input  logic [11:0]      count,
  input  logic             out_stall,
  input  brr_cmd_t         cmd,
  output brr_sts_t         sts,
  output logic             out_valid,
  output logic [16:0]      bits_value,
  output logic             byte_accepted,
  output logic [POS_W-1:0] bytes_unread
);

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int CW     = ((POS_W > 12) ? POS_W : 12) + 1;
  localparam int TW     = ((POS_W + 3 > 15) ? POS_W + 3 : 15) + 1;
  localparam int IW     = POS_W + 1;
  localparam logic [POS_W-1:0] STORE_END = POS_W'(STORE_BYTES);
  localparam logic [TW-1:0]    END_BITS  = TW'(STORE_BYTES * 8);

  // Architectural state.
  logic [POS_W-1:0] rd_byte;
  logic [2:0]       rd_bit;
  logic [POS_W-1:0] fill_end;
  logic [11:0]      accept_left;
  logic [POS_W-1:0] high_water;
  logic [11:0]      fill_limit;

  // Request held for the duration of its work.
  logic [1:0]       it_mode;
  logic [7:0]       it_data;
  logic             it_cstart;
  logic [11:0]      it_clen;
  logic [11:0]      it_count;
  logic             it_ovf;
  logic [POS_W-1:0] it_keep;

  // Read window and its fetch pipeline.
  logic [2:0][7:0] win;
  logic [1:0]      rd_k;
  logic            rd_pend;
  logic            rd_ok;
  logic [1:0]      rd_slot;

  // Compaction copy.
  logic [POS_W-1:0]  cp_i;
  logic              cp_pend;
  logic [ADDR_W-1:0] cp_widx;

  // Memory ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Chunk checks made on the incoming request.
  logic [CW-1:0]    chk_sum;
  logic             ovf_in;
  logic [POS_W-1:0] keep_in;

  assign chk_sum = CW'(chunk_len) + CW'(fill_end);
  assign ovf_in  = chk_sum > CW'(fill_limit);
  assign keep_in = (fill_end > rd_byte) ? fill_end - rd_byte : '0;

  // Fetch and copy addressing.
  logic             cp_go;
  logic [POS_W-1:0] cp_src;
  logic [IW-1:0]    rd_idx;
  logic             rd_in;

  assign cp_go  = cmd.copy_step && (cp_i != it_keep);
  assign cp_src = rd_byte + cp_i;
  assign rd_idx = IW'(rd_byte) + IW'(rd_k);
  assign rd_in  = rd_idx < IW'(high_water);

  always_comb begin
    if (cp_go) begin
      ram_raddr = cp_src[ADDR_W-1:0];
    end else if (rd_in) begin
      ram_raddr = rd_idx[ADDR_W-1:0];
    end else begin
      ram_raddr = '0;
    end
  end

  // Append arithmetic.
  logic [POS_W-1:0] fe1;
  logic [CW-1:0]    room_w;
  logic [11:0]      room;
  logic [11:0]      al1;
  logic             wr_ok;

  assign fe1    = (it_cstart && it_ovf) ? it_keep : fill_end;
  assign room_w = (CW'(fill_limit) > CW'(fe1)) ? CW'(fill_limit) - CW'(fe1) : '0;
  assign room   = room_w[11:0];
  assign al1    = it_cstart ? ((it_clen < room) ? it_clen : room) : accept_left;
  assign wr_ok  = (al1 != 12'd0) && (fe1 < STORE_END);

  // Pointer advance arithmetic.
  logic [2:0]    base_bit;
  logic [4:0]    n_get;
  logic [TW-1:0] nbits;
  logic [TW-1:0] total;
  logic          sat;

  assign base_bit = (it_mode == MODE_SKIP_BYTES) ? 3'd0 : rd_bit;
  assign n_get    = (it_count > 12'(GET_MAX)) ? 5'(GET_MAX) : it_count[4:0];

  always_comb begin
    case (it_mode)
      MODE_GET:        nbits = TW'(n_get);
      MODE_SKIP_BITS:  nbits = TW'(it_count);
      MODE_SKIP_BYTES: nbits = TW'({it_count, 3'b000});
      default:         nbits = '0;
    endcase
  end

  assign total = (TW'(rd_byte) << 3) + TW'(base_bit) + nbits;
  assign sat   = total >= END_BITS;

  // Bit extraction from the window, first byte most significant.
  logic [WIN_BITS-1:0] win_word;
  logic [WIN_BITS-1:0] win_shift;
  logic [4:0]          shamt;
  logic [WIN_BITS-1:0] win_val;

  assign win_word  = {win[0], win[1], win[2]};
  assign win_shift = win_word << rd_bit;
  assign shamt     = 5'(WIN_BITS) - n_get;
  assign win_val   = win_shift >> shamt;

  // Memory write: the copy owns the port while compaction runs.
  assign ram_we    = cp_pend || (cmd.commit && (it_mode == MODE_APPEND) && wr_ok);
  assign ram_waddr = cp_pend ? cp_widx : fe1[ADDR_W-1:0];
  assign ram_wdata = cp_pend ? ram_rdata : it_data;

  // Status.
  assign sts.need_copy = (it_mode == MODE_APPEND) && it_cstart && it_ovf &&
                         (it_keep != '0) && (rd_byte != '0);
  assign sts.get_nz    = (it_mode == MODE_GET) && (it_count != 12'd0);
  assign sts.copy_done = (cp_i == it_keep) && !cp_pend;
  assign sts.rd_last   = (rd_k == 2'd2);
  assign sts.slot_free = !out_valid || !out_stall;

  // State only changes at a commit, which waits for the output slot.
  assign bytes_unread = (fill_end > rd_byte) ? fill_end - rd_byte : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_byte     <= '0;
      rd_bit      <= '0;
      fill_end    <= '0;
      accept_left <= '0;
      high_water  <= '0;
      fill_limit  <= FILL_LIMIT_RST;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      rd_k        <= '0;
      cp_pend     <= 1'b0;
      cp_i        <= '0;
    end else begin
      if (cfg_we) begin
        fill_limit <= cfg_wdata;
      end
      rd_pend <= cmd.rd_issue;
      cp_pend <= cp_go;
      if (cmd.load) begin
        rd_k <= '0;
        cp_i <= '0;
      end else begin
        if (cmd.rd_issue) begin
          rd_k <= rd_k + 2'd1;
        end
        if (cp_go) begin
          cp_i <= cp_i + POS_W'(1);
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        case (it_mode)
          MODE_APPEND: begin
            if (it_cstart && it_ovf) begin
              rd_byte <= '0;
              rd_bit  <= '0;
            end
            if (wr_ok) begin
              fill_end    <= fe1 + POS_W'(1);
              accept_left <= al1 - 12'd1;
              if (fe1 >= high_water) begin
                high_water <= fe1 + POS_W'(1);
              end
            end else begin
              fill_end    <= fe1;
              accept_left <= al1;
            end
          end
          default: begin
            if (sat) begin
              rd_byte <= STORE_END;
              rd_bit  <= '0;
            end else begin
              rd_byte <= total[POS_W+2:3];
              rd_bit  <= total[2:0];
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode   <= mode;
      it_data   <= data_byte;
      it_cstart <= chunk_start;
      it_clen   <= chunk_len;
      it_count  <= count;
      it_ovf    <= ovf_in;
      it_keep   <= keep_in;
    end
    if (cmd.rd_issue) begin
      rd_ok   <= rd_in;
      rd_slot <= rd_k;
    end
    if (rd_pend) begin
      win[rd_slot] <= rd_ok ? ram_rdata : 8'h00;
    end
    if (cp_go) begin
      cp_widx <= cp_i[ADDR_W-1:0];
    end
    if (cmd.commit) begin
      bits_value    <= (it_mode == MODE_GET) ? win_val[16:0] : 17'd0;
      byte_accepted <= (it_mode == MODE_APPEND) && wr_ok;
    end
  end

  brr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/bit_reservoir_reader.sv
// Requests are worked on one at a time, and in_stall stays high until a request has
// committed. A get bits with a nonzero count fetches its three window bytes one by one
// (they share one read port), and a compacting chunk start first copies its keep bytes
// to the bottom of the store; output stalls hold back the commit and add more delay.
// Reset (synchronous, active high) clears the pointers, the fill end and the output
// and loads a fill limit of 2048; unwritten store bytes read as zero, no clearing pass.
`default_nettype none

// The block is split into a controller and a datapath. The controller takes one
// request at a time and sequences the multi-cycle work: the compaction copy, which
// moves the unread bytes to the bottom of the store one byte per cycle, and the
// three-byte window fetch for get bits. The datapath holds the pointers, the fill
// end, the remaining chunk allowance and the byte store; the pointers, the fill end
// and the allowance change in a single commit cycle once the output register is free.
//
// Store bytes that were never written must read as zero. Writes only ever happen
// at most one past the highest position written so far, so a high-water mark tells
// written bytes from unwritten ones, and the memory itself never needs clearing.
//
// While a finished result waits in the output register, the next request is still
// taken and worked on; only its commit waits for the output slot. The bytes_unread
// output is formed from the committed pointers, which cannot move until the
// pending result has been taken.

module bit_reservoir_reader import brr_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  localparam int POS_W = $clog2(STORE_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // Fill limit register write.
  input  logic             cfg_we,
  input  logic [11:0]      cfg_wdata,
  // Request channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic             chunk_start,
  input  logic [11:0]      chunk_len,
  input  logic [11:0]      count,
  // Result channel.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [16:0]      bits_value,
  output logic             byte_accepted,
  output logic [POS_W-1:0] bytes_unread
);

  brr_cmd_t cmd;
  brr_sts_t sts;

  // The controller sequences one request at a time.
  brr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the store, the pointers and the output register.
  brr_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mode          (mode),
    .data_byte     (data_byte),
    .chunk_start   (chunk_start),
    .chunk_len     (chunk_len),
    .count         (count),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .bits_value    (bits_value),
    .byte_accepted (byte_accepted),
    .bytes_unread  (bytes_unread)
  );

endmodule

`default_nettype wire

// File: rtl/core/brr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module brr_checker import brr_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  localparam int POS_W = $clog2(STORE_BYTES + 1)
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [16:0]      bits_value,
  input logic             byte_accepted,
  input logic [POS_W-1:0] bytes_unread
);

  // A request is worked on alone, so the channel closes right after a request.
  `BRR_CHK_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)

  // A held result keeps its value.
  `BRR_CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                out_valid && $stable(bits_value))

  // A stored byte grows the unread count by at most one, compaction included.
  `BRR_CHK_NOW(a_append_unread, clk, rst,
               out_valid && (!$past(out_valid) || !$past(out_stall)) && byte_accepted,
               (bytes_unread >= $past(bytes_unread)) &&
               (bytes_unread <= $past(bytes_unread) + POS_W'(1)))

  // Nonzero read bits come from a get, which only consumes data.
  `BRR_CHK_NOW(a_get_consumes, clk, rst,
               out_valid && (!$past(out_valid) || !$past(out_stall)) && (bits_value != 17'd0),
               !byte_accepted && (bytes_unread <= $past(bytes_unread)))

endmodule

bind bit_reservoir_reader brr_checker #(.STORE_BYTES(STORE_BYTES)) u_brr_checker (.*);

`default_nettype wire
